// ===== hdl/sddc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sddc_pkg
// Shared types and constants for the scheduled display dimming controller.
// ----------------------------------------------------------------------------
package sddc_pkg;

  localparam int TIME_BITS_DEF = 32;

  localparam int CHECK_MS = 10000;
  localparam int RETRY_MS = 2000;
  localparam int HOLD_MS  = 120000;
  localparam int WAKE_MS  = 10000;

  localparam logic [7:0] PROV_FLOOR = 8'd64;
  localparam logic [7:0] WAKE_FLOOR = 8'd20;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [2:0] {
    OP_CHECK   = 3'd0,
    OP_BOOT    = 3'd1,
    OP_REFRESH = 3'd2,
    OP_FORCE   = 3'd3,
    OP_RELEASE = 3'd4,
    OP_PROV    = 3'd5,
    OP_TOUCH   = 3'd6
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCHED_EN   = 3'd0,
    CFG_DIM_START  = 3'd1,
    CFG_DIM_END    = 3'd2,
    CFG_NORMAL_LVL = 3'd3,
    CFG_DIM_LVL    = 3'd4,
    CFG_PANEL      = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic        apply_valid;
    logic        panel_on;
    logic [7:0]  level;
    logic        schedule_says_off;
    logic [15:0] refused_wakes;
    logic        forced_off_flag;
    logic        op_ok;
  } res_t;

endpackage

// ===== hdl/scheduled_display_dimming_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scheduled_display_dimming_controller
// Event-driven panel brightness control with a dim window, confirmed
// brightening, boot hold, forced off, provisioning floor and touch wake.
// ----------------------------------------------------------------------------
// Each accepted transaction's result is registered in the output register or skid entry.
// Throughput: one transaction per cycle while in_stall is low; all state updates are
//   combinational compares and muxes on the state registers.
// A two-entry result buffer lets input continue while one result is stalled.
// Reset (rst_n low, synchronous) restores config defaults and all state.
module scheduled_display_dimming_controller #(
  parameter int TIME_BITS = sddc_pkg::TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [sddc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sddc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [2:0]                      in_op,
  input  logic [31:0]                     in_now_ms,
  input  logic                            in_time_valid,
  input  logic [4:0]                      in_hour,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_apply_valid,
  output logic                            out_panel_on,
  output logic [7:0]                      out_level,
  output logic                            out_schedule_says_off,
  output logic [15:0]                     out_refused_wakes,
  output logic                            out_forced_off_flag,
  output logic                            out_op_ok
);
  import sddc_pkg::*;

  localparam int HW = (TIME_BITS > 17) ? TIME_BITS : 17;

  // configuration
  logic       sched_en_r;
  logic [4:0] dim_start_r, dim_end_r;
  logic [7:0] normal_lvl_r, dim_lvl_r;
  logic       panel_r;

  // controller state
  logic [7:0]           applied_r, applied_nxt;
  logic                 force_r, force_nxt;
  logic                 boot_r, boot_nxt;
  logic [7:0]           pend_lvl_r, pend_lvl_nxt;
  logic                 pend_v_r, pend_v_nxt;
  logic [15:0]          refuse_r, refuse_nxt;
  logic                 prov_r, prov_nxt;
  logic                 first_r, first_nxt;
  logic [TIME_BITS-1:0] next_chk_r, next_chk_nxt;
  logic                 wake_r, wake_nxt;
  logic [TIME_BITS-1:0] wake_exp_r, wake_exp_nxt;
  logic [7:0]           lbw_r, lbw_nxt;

  // result buffer
  logic out_valid_r, skid_valid_r;
  res_t out_data_r, skid_data_r, res_nxt;

  logic                 in_acc, out_pop;
  logic [TIME_BITS-1:0] now_t, d_chk, d_wake;
  logic                 chk_before, wake_before, hold_expired;
  logic                 in_win, res_ok;
  logic [7:0]           tgt, wake_lvl, prov_lvl;
  logic                 apply, ok;

  assign in_acc  = in_valid && !in_stall;
  assign out_pop = out_valid_r && !out_stall;
  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;

  assign now_t  = TIME_BITS'(in_now_ms);
  assign d_chk  = now_t - next_chk_r;
  assign d_wake = now_t - wake_exp_r;
  // wrap-safe "now is before deadline": sign of the modular difference
  assign chk_before   = d_chk[TIME_BITS-1];
  assign wake_before  = d_wake[TIME_BITS-1];
  assign hold_expired = HW'(now_t) > HW'(HOLD_MS);

  // dim window, possibly wrapping past midnight
  always_comb begin
    if (dim_start_r == dim_end_r) begin
      in_win = 1'b0;
    end else if (dim_start_r < dim_end_r) begin
      in_win = (in_hour >= dim_start_r) && (in_hour < dim_end_r);
    end else begin
      in_win = (in_hour >= dim_start_r) || (in_hour < dim_end_r);
    end
  end

  assign res_ok = !sched_en_r || in_time_valid;
  assign tgt    = (sched_en_r && in_time_valid && in_win) ? dim_lvl_r : normal_lvl_r;

  assign wake_lvl = (normal_lvl_r == 8'd0)
                  ? ((dim_lvl_r < WAKE_FLOOR) ? WAKE_FLOOR : dim_lvl_r)
                  : ((normal_lvl_r < WAKE_FLOOR) ? WAKE_FLOOR : normal_lvl_r);
  assign prov_lvl = (normal_lvl_r < PROV_FLOOR) ? PROV_FLOOR : normal_lvl_r;

  always_comb begin
    applied_nxt  = applied_r;
    force_nxt    = force_r;
    boot_nxt     = boot_r;
    pend_lvl_nxt = pend_lvl_r;
    pend_v_nxt   = pend_v_r;
    refuse_nxt   = refuse_r;
    prov_nxt     = prov_r;
    first_nxt    = first_r;
    next_chk_nxt = next_chk_r;
    wake_nxt     = wake_r;
    wake_exp_nxt = wake_exp_r;
    lbw_nxt      = lbw_r;
    apply        = 1'b0;
    ok           = 1'b0;

    // touch wake expiry comes before the op itself
    if (wake_r && !wake_before) begin
      wake_nxt = 1'b0;
      if (panel_r) begin
        applied_nxt = res_ok ? tgt : lbw_r;
        apply       = 1'b1;
      end
    end

    case (op_t'(in_op))
      OP_CHECK: begin
        if (!(wake_nxt || force_r || prov_r) && !(first_r && chk_before)) begin
          first_nxt = 1'b1;
          if (!res_ok) begin
            if (boot_r && hold_expired) begin
              boot_nxt = 1'b0;
              if (panel_r) begin
                applied_nxt = normal_lvl_r;
                apply       = 1'b1;
              end
            end
            next_chk_nxt = now_t + TIME_BITS'(RETRY_MS);
          end else begin
            boot_nxt     = 1'b0;
            next_chk_nxt = now_t + TIME_BITS'(CHECK_MS);
            if (tgt == applied_nxt) begin
              // proposal not confirmed
              if (pend_v_r) begin
                pend_v_nxt = 1'b0;
                refuse_nxt = refuse_r + 16'd1;
              end
            end else if (tgt < applied_nxt ||
                         (pend_v_r && pend_lvl_r == tgt)) begin
              pend_v_nxt = 1'b0;
              if (panel_r) begin
                applied_nxt = tgt;
                apply       = 1'b1;
              end
            end else begin
              pend_lvl_nxt = tgt;
              pend_v_nxt   = 1'b1;
            end
          end
        end
      end
      OP_BOOT: begin
        if (!wake_nxt && !force_r) begin
          boot_nxt = !res_ok;
          if (panel_r) begin
            applied_nxt = res_ok ? tgt : dim_lvl_r;
            apply       = 1'b1;
          end
        end
      end
      OP_REFRESH, OP_RELEASE: begin
        if (op_t'(in_op) == OP_RELEASE) begin
          force_nxt = 1'b0;
        end
        ok = 1'b1;
        if (!wake_nxt && !force_nxt && !prov_r) begin
          if (!res_ok) begin
            ok = 1'b0;
          end else begin
            boot_nxt   = 1'b0;
            pend_v_nxt = 1'b0;
            if (applied_nxt != tgt && panel_r) begin
              applied_nxt = tgt;
              apply       = 1'b1;
            end
          end
        end
      end
      OP_FORCE: begin
        force_nxt = 1'b1;
        if (panel_r) begin
          applied_nxt = 8'd0;
          apply       = 1'b1;
        end
      end
      OP_PROV: begin
        prov_nxt   = 1'b1;
        boot_nxt   = 1'b0;
        pend_v_nxt = 1'b0;
        if (panel_r) begin
          applied_nxt = prov_lvl;
          apply       = 1'b1;
        end
      end
      OP_TOUCH: begin
        if (panel_r && !force_r) begin
          if (wake_nxt) begin
            wake_exp_nxt = now_t + TIME_BITS'(WAKE_MS);
            ok           = 1'b1;
          end else if (applied_nxt == 8'd0) begin
            lbw_nxt      = applied_nxt;
            wake_nxt     = 1'b1;
            wake_exp_nxt = now_t + TIME_BITS'(WAKE_MS);
            applied_nxt  = wake_lvl;
            apply        = 1'b1;
            ok           = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    res_nxt.apply_valid       = apply;
    res_nxt.panel_on          = (applied_nxt != 8'd0);
    res_nxt.level             = applied_nxt;
    res_nxt.schedule_says_off = res_ok ? (tgt == 8'd0) : (boot_nxt && dim_lvl_r == 8'd0);
    res_nxt.refused_wakes     = refuse_nxt;
    res_nxt.forced_off_flag   = force_nxt;
    res_nxt.op_ok             = ok;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sched_en_r   <= 1'b0;
      dim_start_r  <= 5'd22;
      dim_end_r    <= 5'd7;
      normal_lvl_r <= 8'd255;
      dim_lvl_r    <= 8'd0;
      panel_r      <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SCHED_EN:   sched_en_r   <= cfg_wdata[0];
        CFG_DIM_START:  dim_start_r  <= cfg_wdata[4:0];
        CFG_DIM_END:    dim_end_r    <= cfg_wdata[4:0];
        CFG_NORMAL_LVL: normal_lvl_r <= cfg_wdata;
        CFG_DIM_LVL:    dim_lvl_r    <= cfg_wdata;
        CFG_PANEL:      panel_r      <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // controller state, updated once per accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      applied_r  <= 8'd255;
      force_r    <= 1'b0;
      boot_r     <= 1'b0;
      pend_lvl_r <= 8'd0;
      pend_v_r   <= 1'b0;
      refuse_r   <= 16'd0;
      prov_r     <= 1'b0;
      first_r    <= 1'b0;
      next_chk_r <= '0;
      wake_r     <= 1'b0;
      wake_exp_r <= '0;
      lbw_r      <= 8'd255;
    end else if (in_acc) begin
      applied_r  <= applied_nxt;
      force_r    <= force_nxt;
      boot_r     <= boot_nxt;
      pend_lvl_r <= pend_lvl_nxt;
      pend_v_r   <= pend_v_nxt;
      refuse_r   <= refuse_nxt;
      prov_r     <= prov_nxt;
      first_r    <= first_nxt;
      next_chk_r <= next_chk_nxt;
      wake_r     <= wake_nxt;
      wake_exp_r <= wake_exp_nxt;
      lbw_r      <= lbw_nxt;
    end
  end

  // two-entry result buffer: output register plus skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_pop) begin
      out_valid_r  <= skid_valid_r || in_acc;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r) begin
      out_valid_r <= in_acc;
    end else if (in_acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_pop) begin
      out_data_r <= skid_valid_r ? skid_data_r : res_nxt;
    end else if (!out_valid_r) begin
      out_data_r <= res_nxt;
    end else if (in_acc) begin
      skid_data_r <= res_nxt;
    end
  end

  assign out_apply_valid       = out_data_r.apply_valid;
  assign out_panel_on          = out_data_r.panel_on;
  assign out_level             = out_data_r.level;
  assign out_schedule_says_off = out_data_r.schedule_says_off;
  assign out_refused_wakes     = out_data_r.refused_wakes;
  assign out_forced_off_flag   = out_data_r.forced_off_flag;
  assign out_op_ok             = out_data_r.op_ok;

endmodule

// ===== hdl/sddc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sddc_checker
// Port-level checks for the scheduled display dimming controller.
// ----------------------------------------------------------------------------
module sddc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_apply_valid,
  input logic        out_panel_on,
  input logic [7:0]  out_level,
  input logic [15:0] out_refused_wakes,
  input logic        out_forced_off_flag
);

  // buffer empties on reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("result buffer not empty after reset");

  // power command always tracks the reported level
  a_power_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_panel_on == (out_level != 8'd0))
    else $error("panel_on disagrees with level");

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_level)
      && $stable(out_refused_wakes) && $stable(out_apply_valid)
      && $stable(out_forced_off_flag))
    else $error("stalled result changed");

  // input can only be stalled while a result is waiting downstream
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

endmodule

bind scheduled_display_dimming_controller sddc_checker u_sddc_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_apply_valid     (out_apply_valid),
  .out_panel_on        (out_panel_on),
  .out_level           (out_level),
  .out_refused_wakes   (out_refused_wakes),
  .out_forced_off_flag (out_forced_off_flag)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the scheduled display dimming controller. A short
// directed script covers reset values, forced off, touch wake, confirmed
// brightening, refused wakes and the boot hold. Random event streams then run
// under many register settings, with and without input idling and output stall,
// and a closing script covers provisioning, which stays latched until reset.
// Each result is checked field by field against the script or an in-bench model.
// ----------------------------------------------------------------------------
module tb;
  import sddc_pkg::*;

  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int N_PHASES = 10;
  localparam int PHASE_EVENTS = 105;
  localparam int CLOSING_EVENTS = 40;
  localparam int SETTLE_CYCLES = 4;
  localparam int REPORT_LIMIT = 40;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef enum logic [1:0] {ROW_EVENT, ROW_EVENT_TYPED, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    cfg_idx_t   reg_idx;
    logic [7:0] reg_val;
    logic [2:0] op;
    logic [31:0] now_ms;
    logic       time_valid;
    logic [4:0] hour;
    res_t       want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [7:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_op = '0;
  logic [31:0] in_now_ms = '0;
  logic        in_time_valid = 1'b0;
  logic [4:0]  in_hour = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_apply_valid;
  logic        out_panel_on;
  logic [7:0]  out_level;
  logic        out_schedule_says_off;
  logic [15:0] out_refused_wakes;
  logic        out_forced_off_flag;
  logic        out_op_ok;

  // model copy of the registers, at their reset values
  logic       sched_en = 1'b0;
  logic [4:0] win_start = 5'd22;
  logic [4:0] win_end = 5'd7;
  logic [7:0] lvl_normal = 8'd255;
  logic [7:0] lvl_dim = 8'd0;
  logic       panel_ok = 1'b1;

  // model copy of the state
  logic [7:0]  cur_level = 8'd255;
  logic        forced = 1'b0;
  logic        holding_boot = 1'b0;
  logic [7:0]  pend_level = 8'd0;
  logic        pend_valid = 1'b0;
  logic [15:0] refusals = 16'd0;
  logic        prov_hold = 1'b0;
  logic        checked_once = 1'b0;
  logic [31:0] next_check = 32'd0;
  logic        waking = 1'b0;
  logic [31:0] wake_end = 32'd0;
  logic [7:0]  level_pre_wake = 8'd255;
  logic        level_sent;

  res_t        dimmer_reports[$];
  stim_row_t   directed_rows[$];
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned events_sent = 0;
  int unsigned scripted_events = 0;
  int unsigned results_seen = 0;
  int unsigned wakes_started = 0;
  int unsigned cycle_count = 0;
  logic [31:0] clock_ms = 32'd0;
  logic [4:0]  wall_hour = 5'd0;

  scheduled_display_dimming_controller i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_op                 (in_op),
    .in_now_ms             (in_now_ms),
    .in_time_valid         (in_time_valid),
    .in_hour               (in_hour),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_apply_valid       (out_apply_valid),
    .out_panel_on          (out_panel_on),
    .out_level             (out_level),
    .out_schedule_says_off (out_schedule_says_off),
    .out_refused_wakes     (out_refused_wakes),
    .out_forced_off_flag   (out_forced_off_flag),
    .out_op_ok             (out_op_ok)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // ---------------------------------------------------------------- model
  // signed difference, so deadlines survive the 32-bit wrap
  function automatic logic time_before(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] diff;
    diff = a - b;
    return diff[31];
  endfunction

  function automatic logic window_target(input logic tv, input logic [4:0] hr,
                                         output logic [7:0] tgt);
    logic dim;
    tgt = lvl_normal;
    if (!sched_en) return 1'b1;
    if (!tv) return 1'b0;
    if (win_start == win_end) dim = 1'b0;
    else if (win_start < win_end) dim = (hr >= win_start) && (hr < win_end);
    else dim = (hr >= win_start) || (hr < win_end);
    tgt = dim ? lvl_dim : lvl_normal;
    return 1'b1;
  endfunction

  function automatic void drive_level(input logic [7:0] lv);
    if (!panel_ok) return;
    cur_level = lv;
    level_sent = 1'b1;
  endfunction

  function automatic logic refresh_level(input logic tv, input logic [4:0] hr);
    logic [7:0] tgt;
    if (waking || forced || prov_hold) return 1'b1;
    if (!window_target(tv, hr, tgt)) return 1'b0;
    holding_boot = 1'b0;
    pend_valid = 1'b0;
    if (cur_level != tgt) drive_level(tgt);
    return 1'b1;
  endfunction

  function automatic res_t step_dimmer(input logic [2:0] op, input logic [31:0] now,
                                       input logic tv, input logic [4:0] hr);
    res_t       r;
    logic [7:0] tgt;
    logic [7:0] wake_lvl;
    logic       ok;
    level_sent = 1'b0;
    ok = 1'b0;
    if (waking && !time_before(now, wake_end)) begin
      waking = 1'b0;
      if (window_target(tv, hr, tgt)) drive_level(tgt);
      else drive_level(level_pre_wake);
    end
    case (op)
      OP_CHECK: begin
        if (!(waking || forced || prov_hold) &&
            !(checked_once && time_before(now, next_check))) begin
          checked_once = 1'b1;
          if (!window_target(tv, hr, tgt)) begin
            if (holding_boot && now > HOLD_MS) begin
              holding_boot = 1'b0;
              drive_level(lvl_normal);
            end
            next_check = now + RETRY_MS;
          end else begin
            holding_boot = 1'b0;
            next_check = now + CHECK_MS;
            if (tgt == cur_level) begin
              if (pend_valid) begin
                pend_valid = 1'b0;
                refusals = refusals + 16'd1;
              end
            end else if (tgt < cur_level || (pend_valid && pend_level == tgt)) begin
              // darker goes at once; brighter only once confirmed
              pend_valid = 1'b0;
              drive_level(tgt);
            end else begin
              pend_level = tgt;
              pend_valid = 1'b1;
            end
          end
        end
      end
      OP_BOOT: begin
        if (!(waking || forced)) begin
          if (window_target(tv, hr, tgt)) begin
            holding_boot = 1'b0;
            drive_level(tgt);
          end else begin
            holding_boot = 1'b1;
            drive_level(lvl_dim);
          end
        end
      end
      OP_REFRESH: ok = refresh_level(tv, hr);
      OP_FORCE: begin
        forced = 1'b1;
        drive_level(8'd0);
      end
      OP_RELEASE: begin
        forced = 1'b0;
        ok = refresh_level(tv, hr);
      end
      OP_PROV: begin
        prov_hold = 1'b1;
        holding_boot = 1'b0;
        pend_valid = 1'b0;
        drive_level(lvl_normal < PROV_FLOOR ? PROV_FLOOR : lvl_normal);
      end
      OP_TOUCH: begin
        if (panel_ok && !forced) begin
          if (waking) begin
            wake_end = now + WAKE_MS;
            ok = 1'b1;
          end else if (cur_level == 8'd0) begin
            level_pre_wake = cur_level;
            waking = 1'b1;
            wake_end = now + WAKE_MS;
            wake_lvl = (lvl_normal == 8'd0) ? lvl_dim : lvl_normal;
            if (wake_lvl < WAKE_FLOOR) wake_lvl = WAKE_FLOOR;
            drive_level(wake_lvl);
            wakes_started++;
            ok = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.apply_valid = level_sent;
    r.panel_on = (cur_level != 8'd0);
    r.level = cur_level;
    if (window_target(tv, hr, tgt)) r.schedule_says_off = (tgt == 8'd0);
    else r.schedule_says_off = holding_boot && (lvl_dim == 8'd0);
    r.refused_wakes = refusals;
    r.forced_off_flag = forced;
    r.op_ok = ok;
    return r;
  endfunction

  // ---------------------------------------------------------- script rows
  function automatic res_t report(input int av, input int on, input int lvl,
                                  input int off, input int refused,
                                  input int forced_f, input int ok_f);
    res_t r;
    r.apply_valid = av[0];
    r.panel_on = on[0];
    r.level = lvl[7:0];
    r.schedule_says_off = off[0];
    r.refused_wakes = refused[15:0];
    r.forced_off_flag = forced_f[0];
    r.op_ok = ok_f[0];
    return r;
  endfunction

  function automatic stim_row_t ev_typed(input logic [2:0] op, input logic [31:0] now,
                                         input logic tv, input logic [4:0] hr,
                                         input res_t want);
    stim_row_t r;
    r = '0;
    r.kind = ROW_EVENT_TYPED;
    r.op = op;
    r.now_ms = now;
    r.time_valid = tv;
    r.hour = hr;
    r.want = want;
    return r;
  endfunction

  function automatic stim_row_t ev(input logic [2:0] op, input logic [31:0] now,
                                   input logic tv, input logic [4:0] hr);
    stim_row_t r;
    r = ev_typed(op, now, tv, hr, '0);
    r.kind = ROW_EVENT;
    return r;
  endfunction

  function automatic stim_row_t reg_wr(input cfg_idx_t idx, input logic [7:0] val);
    stim_row_t r;
    r = '0;
    r.kind = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic void put_row(input stim_row_t r);
    directed_rows.push_back(r);
  endfunction

  // -------------------------------------------------------------- drivers
  task automatic send_event(input logic [2:0] op, input logic [31:0] now, input logic tv,
                            input logic [4:0] hr, input logic typed, input res_t want);
    res_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_now_ms <= now;
    in_time_valid <= tv;
    in_hour <= hr;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predicted = step_dimmer(op, now, tv, hr);
    dimmer_reports.push_back(typed ? want : predicted);
    events_sent++;
  endtask

  task automatic drain();
    while (dimmer_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register writes happen only with nothing in flight
  task automatic program_reg(input cfg_idx_t idx, input logic [7:0] val);
    in_valid <= 1'b0;
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SCHED_EN:   sched_en = val[0];
      CFG_DIM_START:  win_start = val[4:0];
      CFG_DIM_END:    win_end = val[4:0];
      CFG_NORMAL_LVL: lvl_normal = val;
      CFG_DIM_LVL:    lvl_dim = val;
      CFG_PANEL:      panel_ok = val[0];
      default: ;
    endcase
  endtask

  task automatic walk_rows(input int first, input int last);
    stim_row_t row;
    for (int i = first; i <= last; i++) begin
      row = directed_rows[i];
      if (row.kind == ROW_REG) begin
        program_reg(row.reg_idx, row.reg_val);
      end else begin
        send_event(row.op, row.now_ms, row.time_valid, row.hour,
                   row.kind == ROW_EVENT_TYPED, row.want);
        scripted_events++;
      end
    end
  endtask

  // time mostly advances around the check interval so that confirmations,
  // refusals and wake expiries happen; some reboots, wraps and wild values
  task automatic send_random_event();
    int unsigned sel;
    logic [2:0]  op;
    logic        tv;
    logic [4:0]  hr;
    sel = $urandom_range(99);
    if (sel < 55) clock_ms += $urandom_range(10500, 1500);
    else if (sel < 75) clock_ms += $urandom_range(2500);
    else if (sel < 85) clock_ms += $urandom_range(200);
    else if (sel < 92) clock_ms = $urandom_range(150000);
    else if (sel < 96) clock_ms = 32'hFFFF_0000 | $urandom_range(16'hFFFF);
    else clock_ms = $urandom();
    if ($urandom_range(99) < 20) wall_hour = (wall_hour == 5'd23) ? 5'd0 : wall_hour + 5'd1;
    hr = ($urandom_range(99) < 5) ? 5'($urandom_range(31)) : wall_hour;
    tv = ($urandom_range(99) < 85);
    sel = $urandom_range(99);
    if (sel < 55) op = OP_CHECK;
    else if (sel < 65) op = OP_BOOT;
    else if (sel < 75) op = OP_REFRESH;
    else if (sel < 80) op = OP_FORCE;
    else if (sel < 88) op = OP_RELEASE;
    else if (sel < 98) op = OP_TOUCH;
    else op = OP_UNUSED;
    send_event(op, clock_ms, tv, hr, 1'b0, '0);
  endtask

  // -------------------------------------------------------------- checker
  task automatic compare_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (dimmer_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: result transaction with none outstanding, %s %0d",
                   $time, "expected none, actual level", out_level);
      end else begin
        want = dimmer_reports.pop_front();
        compare_field("apply_valid", 16'(want.apply_valid), 16'(out_apply_valid));
        compare_field("panel_on", 16'(want.panel_on), 16'(out_panel_on));
        compare_field("level", 16'(want.level), 16'(out_level));
        compare_field("schedule_says_off", 16'(want.schedule_says_off),
                      16'(out_schedule_says_off));
        compare_field("refused_wakes", want.refused_wakes, out_refused_wakes);
        compare_field("forced_off_flag", 16'(want.forced_off_flag),
                      16'(out_forced_off_flag));
        compare_field("op_ok", 16'(want.op_ok), 16'(out_op_ok));
      end
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // ------------------------------------------------------------- stimulus
  initial begin : stimulus
    int         opening_len;
    int         mode;
    logic       s_en;
    logic       p_on;
    logic [4:0] h_start;
    logic [4:0] h_end;
    logic [7:0] l_norm;
    logic [7:0] l_dim;

    // opening script, reset register values (schedule off, full brightness)
    put_row(ev_typed(OP_CHECK,   32'd0,         1'b0, 5'd0,  report(0, 1, 255, 0, 0, 0, 0)));
    put_row(ev_typed(OP_REFRESH, 32'd5,         1'b0, 5'd0,  report(0, 1, 255, 0, 0, 0, 1)));
    put_row(ev_typed(OP_FORCE,   32'hFFFF_FFFF, 1'b1, 5'd31, report(1, 0, 0, 0, 0, 1, 0)));
    put_row(ev_typed(OP_TOUCH,   32'd100,       1'b1, 5'd0,  report(0, 0, 0, 0, 0, 1, 0)));
    put_row(ev_typed(OP_BOOT,    32'd150,       1'b0, 5'd0,  report(0, 0, 0, 0, 0, 1, 0)));
    put_row(ev_typed(OP_CHECK,   32'd20000,     1'b1, 5'd12, report(0, 0, 0, 0, 0, 1, 0)));
    put_row(ev_typed(OP_RELEASE, 32'd21000,     1'b0, 5'd0,  report(1, 1, 255, 0, 0, 0, 1)));
    put_row(ev_typed(OP_UNUSED,  32'd22000,     1'b1, 5'd31, report(0, 1, 255, 0, 0, 0, 0)));
    // window 22..7 wrapping midnight, dim level off
    put_row(reg_wr(CFG_SCHED_EN, 8'd1));
    put_row(ev_typed(OP_CHECK,   32'd30000,     1'b1, 5'd23, report(1, 0, 0, 1, 0, 0, 0)));
    put_row(ev_typed(OP_TOUCH,   32'd31000,     1'b1, 5'd23, report(1, 1, 255, 1, 0, 0, 1)));
    put_row(ev_typed(OP_TOUCH,   32'd35000,     1'b1, 5'd23, report(0, 1, 255, 1, 0, 0, 1)));
    put_row(ev_typed(OP_CHECK,   32'd40000,     1'b1, 5'd23, report(0, 1, 255, 1, 0, 0, 0)));
    // wake expires exactly at its deadline
    put_row(ev_typed(OP_CHECK,   32'd45000,     1'b1, 5'd6,  report(1, 0, 0, 1, 0, 0, 0)));
    // brighten proposed then refused, proposed again then confirmed
    put_row(ev_typed(OP_CHECK,   32'd55000,     1'b1, 5'd7,  report(0, 0, 0, 0, 0, 0, 0)));
    put_row(ev_typed(OP_CHECK,   32'd65000,     1'b1, 5'd6,  report(0, 0, 0, 1, 1, 0, 0)));
    put_row(ev_typed(OP_CHECK,   32'd75000,     1'b1, 5'd8,  report(0, 0, 0, 0, 1, 0, 0)));
    put_row(ev_typed(OP_CHECK,   32'd80000,     1'b1, 5'd8,  report(0, 0, 0, 0, 1, 0, 0)));
    put_row(ev_typed(OP_CHECK,   32'd85000,     1'b1, 5'd8,  report(1, 1, 255, 0, 1, 0, 0)));
    // boot hold at the dim level, released by the 120 s timeout
    put_row(ev_typed(OP_BOOT,    32'd1000,      1'b0, 5'd0,  report(1, 0, 0, 1, 1, 0, 0)));
    put_row(ev_typed(OP_CHECK,   32'd100000,    1'b0, 5'd0,  report(0, 0, 0, 1, 1, 0, 0)));
    put_row(ev_typed(OP_CHECK,   32'd130000,    1'b0, 5'd0,  report(1, 1, 255, 0, 1, 0, 0)));
    // deadline compare across the wrap, out-of-range hour inside the window
    put_row(ev(OP_CHECK,   32'hFFFF_F000, 1'b1, 5'd23));
    put_row(ev(OP_CHECK,   32'd200000,    1'b1, 5'd30));
    // panel absent: nothing gets applied
    put_row(reg_wr(CFG_PANEL, 8'd0));
    put_row(ev(OP_TOUCH,   32'd201000,    1'b1, 5'd30));
    put_row(ev(OP_FORCE,   32'd202000,    1'b1, 5'd30));
    put_row(ev(OP_RELEASE, 32'd203000,    1'b1, 5'd10));
    put_row(reg_wr(CFG_PANEL, 8'd1));
    put_row(ev(OP_REFRESH, 32'd204000,    1'b1, 5'd10));
    opening_len = directed_rows.size();
    // closing script: provisioning latches until reset, so it runs last
    put_row(ev(OP_RELEASE, 32'd900000,    1'b1, 5'd12));
    put_row(reg_wr(CFG_NORMAL_LVL, 8'd10));
    put_row(ev(OP_PROV,    32'd900100,    1'b1, 5'd12));
    put_row(ev(OP_CHECK,   32'd950000,    1'b1, 5'd12));
    put_row(ev(OP_REFRESH, 32'd950001,    1'b1, 5'd12));
    put_row(reg_wr(CFG_NORMAL_LVL, 8'd200));
    put_row(ev(OP_PROV,    32'd950002,    1'b0, 5'd0));
    put_row(ev(OP_BOOT,    32'd950003,    1'b0, 5'd0));
    put_row(ev(OP_FORCE,   32'd950004,    1'b1, 5'd3));
    put_row(ev(OP_RELEASE, 32'd950005,    1'b1, 5'd3));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 12;
    stall_pct = 45;
    walk_rows(0, opening_len - 1);

    for (int phase = 0; phase < N_PHASES; phase++) begin
      mode = phase * 3 / N_PHASES;
      case (phase)
        0: {s_en, h_start, h_end, l_norm, l_dim, p_on} = {1'b1, 5'd22, 5'd7,  8'd255, 8'd0,   1'b1};
        1: {s_en, h_start, h_end, l_norm, l_dim, p_on} = {1'b1, 5'd8,  5'd17, 8'd200, 8'd30,  1'b1};
        2: {s_en, h_start, h_end, l_norm, l_dim, p_on} = {1'b1, 5'd5,  5'd5,  8'd128, 8'd10,  1'b1};
        3: {s_en, h_start, h_end, l_norm, l_dim, p_on} = {1'b0, 5'd0,  5'd23, 8'd0,   8'd255, 1'b1};
        4: {s_en, h_start, h_end, l_norm, l_dim, p_on} = {1'b1, 5'd23, 5'd0,  8'd10,  8'd0,   1'b1};
        5: {s_en, h_start, h_end, l_norm, l_dim, p_on} = {1'b1, 5'd0,  5'd23, 8'd255, 8'd255, 1'b0};
        6: {s_en, h_start, h_end, l_norm, l_dim, p_on} = {1'b1, 5'd20, 5'd6,  8'd0,   8'd0,   1'b1};
        7: {s_en, h_start, h_end, l_norm, l_dim, p_on} = {1'b1, 5'd0,  5'd1,  8'd1,   8'd254, 1'b1};
        default: begin
          s_en = 1'($urandom_range(1));
          h_start = 5'($urandom_range(23));
          h_end = 5'($urandom_range(23));
          l_norm = 8'($urandom_range(255));
          l_dim = ($urandom_range(1) != 0) ? 8'd0 : 8'($urandom_range(255));
          p_on = ($urandom_range(9) != 0);
        end
      endcase
      program_reg(CFG_SCHED_EN, {7'd0, s_en});
      program_reg(CFG_DIM_START, {3'd0, h_start});
      program_reg(CFG_DIM_END, {3'd0, h_end});
      program_reg(CFG_NORMAL_LVL, l_norm);
      program_reg(CFG_DIM_LVL, l_dim);
      program_reg(CFG_PANEL, {7'd0, p_on});
      send_idle_pct = (mode == 0) ? 12 : (mode == 1) ? 45 : 0;
      stall_pct = (mode == 0) ? 45 : (mode == 1) ? 12 : 0;
      repeat (PHASE_EVENTS) send_random_event();
    end

    walk_rows(opening_len, directed_rows.size() - 1);
    repeat (CLOSING_EVENTS) send_random_event();
    in_valid <= 1'b0;
    drain();

    $display("Ran %0d event transactions (%0d scripted) over %0d register settings",
             events_sent, scripted_events, N_PHASES + 1);
    $display("Checked %0d results; model saw %0d touch wakes, %0d refused wakes; %0d mismatches",
             results_seen, wakes_started, refusals, mismatches);
    if (mismatches == 0 && dimmer_reports.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
